FILE: rtl/core/chte_pkg.sv
package chte_pkg;

   // Command codes of a request transaction.
   typedef enum logic [1:0] {
      CMD_CONTAINS = 2'd0,
      CMD_OBTAIN   = 2'd1,
      CMD_INSERT   = 2'd2,
      CMD_AT       = 2'd3
   } cmd_type;

   // Status codes of a response transaction.
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DUP      = 2'd1,
      ST_FULL     = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   localparam int unsigned CMD_BITS       = 2;
   localparam int unsigned POS_BITS       = 8;
   localparam int unsigned CFG_BITS       = 7;
   localparam int unsigned DEFAULT_BUCKET = 16;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture request and start modulo
      logic mod_step;   // one restoring division step
      logic head_rd;    // read chain head and length of current bucket
      logic ent_rd;     // read entry at current pointer
      logic walk_adv;   // move pointer along chain
      logic cnt_adv;    // move to next bucket while counting positions
      logic do_link;    // write fresh entry and fix up link
      logic set_resp;   // register the response
   } cmd_bus_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_busy;   // bucket tables still being cleared after reset
      logic mod_done;
      logic ptr_null;
      logic key_eq;
      logic key_gt;
      logic pool_full;
      logic walk_over;  // step limit reached
      logic pos_here;   // position falls in current bucket
      logic last_bucket;
      logic offset_zero;
   } stat_bus_type;

endpackage

FILE: rtl/core/chte_if.sv
interface chte_req_if #(parameter int KEY_BITS = 32, parameter int VALUE_BITS = 32);
   logic                  valid;
   logic                  ready;
   logic [1:0]            command;
   logic [KEY_BITS-1:0]   key;
   logic [VALUE_BITS-1:0] value_in;
   logic [7:0]            position;
   modport source (output valid, command, key, value_in, position, input ready);
   modport sink (input valid, command, key, value_in, position, output ready);
endinterface

interface chte_rsp_if #(parameter int VALUE_BITS = 32);
   logic                  valid;
   logic                  ready;
   logic                  found;
   logic [VALUE_BITS-1:0] value_out;
   logic [1:0]            status;
   modport source (output valid, found, value_out, status, input ready);
   modport sink (input valid, found, value_out, status, output ready);
endinterface

FILE: rtl/core/chte_ctrl.sv
module chte_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_fire,
   input  chte_pkg::cmd_type     req_cmd,
   input  chte_pkg::cmd_type     cmd,
   input  logic                  rsp_busy,
   input  chte_pkg::stat_bus_type st,
   output logic                  idle,
   output chte_pkg::cmd_bus_type cb,
   output logic                  res_found,
   output chte_pkg::status_type  res_status
);

   typedef enum logic [9:0] {
      S_CLR   = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_MOD   = 10'b0000000100,
      S_HEAD  = 10'b0000001000,
      S_ERD   = 10'b0000010000,
      S_ECMP  = 10'b0000100000,
      S_LINK  = 10'b0001000000,
      S_CNT   = 10'b0010000000,
      S_PWALK = 10'b0100000000,
      S_RESP  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic found_ff, found_in;
   chte_pkg::status_type status_ff, status_in;

   assign idle       = (state_ff == S_IDLE);
   assign res_found  = found_ff;
   assign res_status = status_ff;

   // Next state and command decode.
   always_comb begin
      state_in  = state_ff;
      found_in  = found_ff;
      status_in = status_ff;
      cb        = '0;
      unique case (state_ff)
         S_CLR: begin
            if (!st.clr_busy) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               cb.load   = 1'b1;
               found_in  = 1'b0;
               status_in = chte_pkg::ST_OK;
               state_in  = (req_cmd == chte_pkg::CMD_AT) ? S_CNT : S_MOD;
            end
         end
         S_MOD: begin
            if (st.mod_done) begin
               state_in = S_HEAD;
            end else begin
               cb.mod_step = 1'b1;
            end
         end
         S_HEAD: begin
            cb.head_rd = 1'b1;
            state_in   = S_ERD;
         end
         S_ERD: begin
            if (st.ptr_null || st.walk_over) begin
               state_in = (cmd == chte_pkg::CMD_INSERT) ? S_LINK : S_RESP;
            end else begin
               cb.ent_rd = 1'b1;
               state_in  = S_ECMP;
            end
         end
         S_ECMP: begin
            priority if (st.key_eq) begin
               if (cmd == chte_pkg::CMD_INSERT) begin
                  status_in = chte_pkg::ST_DUP;
               end else begin
                  found_in = 1'b1;
               end
               state_in = S_RESP;
            end else if (st.key_gt) begin
               state_in = (cmd == chte_pkg::CMD_INSERT) ? S_LINK : S_RESP;
            end else begin
               cb.walk_adv = 1'b1;
               state_in    = S_ERD;
            end
         end
         S_LINK: begin
            if (st.pool_full) begin
               status_in = chte_pkg::ST_FULL;
            end else begin
               cb.do_link = 1'b1;
            end
            state_in = S_RESP;
         end
         S_CNT: begin
            if (st.pos_here) begin
               cb.head_rd = 1'b1;
               state_in   = S_PWALK;
            end else if (st.last_bucket) begin
               status_in = chte_pkg::ST_RANGE;
               state_in  = S_RESP;
            end else begin
               cb.cnt_adv = 1'b1;
            end
         end
         S_PWALK: begin
            if (st.ptr_null) begin
               status_in = chte_pkg::ST_RANGE;
               state_in  = S_RESP;
            end else if (st.offset_zero) begin
               cb.ent_rd = 1'b1;
               found_in  = 1'b1;
               state_in  = S_RESP;
            end else begin
               cb.walk_adv = 1'b1;
            end
         end
         S_RESP: begin
            if (!rsp_busy) begin
               cb.set_resp = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLR;
         found_ff  <= 1'b0;
         status_ff <= chte_pkg::ST_OK;
      end else begin
         state_ff  <= state_in;
         found_ff  <= found_in;
         status_ff <= status_in;
      end
   end

endmodule

FILE: rtl/core/chte_dp.sv
module chte_dp #(
   parameter int MAX_BUCKETS  = 64,
   parameter int POOL_ENTRIES = 256,
   parameter int KEY_BITS     = 32,
   parameter int VALUE_BITS   = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  chte_pkg::cmd_bus_type  cb,
   input  logic [1:0]             req_command,
   input  logic [KEY_BITS-1:0]    req_key,
   input  logic [VALUE_BITS-1:0]  req_value,
   input  logic [7:0]             req_position,
   input  logic [6:0]             csr_value,
   input  logic                   csr_we,
   output chte_pkg::stat_bus_type st,
   output chte_pkg::cmd_type      cmd,
   output logic [VALUE_BITS-1:0]  val_rd
);

   localparam int BB = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int PB = $clog2(POOL_ENTRIES + 1);
   localparam int EB = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
   localparam int CB = $clog2(MAX_BUCKETS + 1);
   localparam int AB = PB + 1;
   localparam int KC = $clog2(KEY_BITS + 1);
   localparam logic [PB-1:0] NULL_L = PB'(POOL_ENTRIES);

   // Bucket count register.
   logic [6:0] bcnt_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         bcnt_ff <= 7'(chte_pkg::DEFAULT_BUCKET);
      end else if (csr_we) begin
         bcnt_ff <= csr_value;
      end
   end

   logic [CB-1:0] eff;
   always_comb begin
      logic [6:0] b;
      b = (bcnt_ff == '0) ? 7'(chte_pkg::DEFAULT_BUCKET) : bcnt_ff;
      if (32'(b) > 32'(MAX_BUCKETS)) begin
         eff = CB'(MAX_BUCKETS);
      end else begin
         eff = CB'(b);
      end
   end

   // Captured request.
   chte_pkg::cmd_type     cmd_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] vin_ff;
   logic [7:0]            pos_ff;
   assign cmd = cmd_ff;

   // Restoring division: one key bit per cycle gives key mod buckets.
   logic [KEY_BITS-1:0] quo_ff;
   logic [CB:0]         rem_ff;
   logic [CB:0]         rem_in;
   logic [KC-1:0]       mcnt_ff;
   logic [CB:0]         rem_sh;
   assign rem_sh = {rem_ff[CB-1:0], quo_ff[KEY_BITS-1]};
   assign rem_in = (rem_sh >= (CB+1)'(eff)) ? rem_sh - (CB+1)'(eff) : rem_sh;

   // Bucket tables, pool bookkeeping and the bucket pointer.
   logic [PB-1:0] head_mem [MAX_BUCKETS];
   logic [PB-1:0] len_mem  [MAX_BUCKETS];
   logic [PB-1:0] head_rd_ff;
   logic [PB-1:0] len_rd_ff;
   logic [CB-1:0] clr_ff;
   logic          clr_busy;
   logic [PB-1:0] used_ff;
   logic [BB-1:0] bkt_ff;
   logic [BB-1:0] bkt_in;
   logic [AB-1:0] before_ff;

   // Walk state.
   logic [PB-1:0] cur_ff;
   logic [PB-1:0] prev_ff;
   logic [PB-1:0] steps_ff;
   logic [PB-1:0] cnt_len;

   // Entry memories.
   logic [KEY_BITS-1:0]   mkey  [POOL_ENTRIES];
   logic [VALUE_BITS-1:0] mval  [POOL_ENTRIES];
   logic [PB-1:0]         mlink [POOL_ENTRIES];
   logic [KEY_BITS-1:0]   rkey_ff;
   logic [PB-1:0]         rlink_ff;
   logic [VALUE_BITS-1:0] rval_ff;
   logic [EB-1:0]         cur_a;
   logic [EB-1:0]         prev_a;
   logic [EB-1:0]         used_a;
   logic [EB-1:0]         link_a;
   logic [PB-1:0]         link_d;
   assign cur_a  = cur_ff[EB-1:0];
   assign prev_a = prev_ff[EB-1:0];
   assign used_a = used_ff[EB-1:0];
   assign val_rd = rval_ff;
   assign cnt_len = len_rd_ff;

   // The link memory is read at the pointer; the entry data follows it.
   logic link_pend_ff;

   // One link write port: the fresh entry first, its predecessor (if any) in the cycle after.
   assign link_a = link_pend_ff ? prev_a : used_a;
   assign link_d = link_pend_ff ? (used_ff - PB'(1)) : cur_ff;

   always_ff @(posedge clock) begin
      if (cb.ent_rd) begin
         rkey_ff  <= mkey[cur_a];
         rval_ff  <= mval[cur_a];
         rlink_ff <= mlink[cur_a];
      end
      if (cb.do_link) begin
         mkey[used_a] <= key_ff;
         mval[used_a] <= vin_ff;
      end
      if (cb.do_link || link_pend_ff) begin
         mlink[link_a] <= link_d;
      end
   end

   // Next bucket pointer; the bucket tables are read at it every cycle.
   always_comb begin
      bkt_in = bkt_ff;
      priority if (cb.load) begin
         bkt_in = '0;
      end else if (cb.cnt_adv) begin
         bkt_in = bkt_ff + BB'(1);
      end else if (cb.mod_step && (mcnt_ff == KC'(KEY_BITS - 1))) begin
         bkt_in = rem_in[BB-1:0];
      end
   end

   // Clearing pass over the bucket tables after reset, one bucket a cycle.
   assign clr_busy = (clr_ff < CB'(MAX_BUCKETS));
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (clr_busy) begin
         clr_ff <= clr_ff + CB'(1);
      end
   end

   // Bucket tables: registered read at the next bucket, one write a cycle.
   always_ff @(posedge clock) begin
      head_rd_ff <= head_mem[bkt_in];
      len_rd_ff  <= len_mem[bkt_in];
      if (clr_busy) begin
         head_mem[clr_ff[BB-1:0]] <= NULL_L;
         len_mem[clr_ff[BB-1:0]]  <= '0;
      end else if (cb.do_link) begin
         len_mem[bkt_ff] <= len_rd_ff + PB'(1);
         if (prev_ff == NULL_L) begin
            head_mem[bkt_ff] <= used_ff;
         end
      end
   end

   // Request capture, modulo, walk and counting.
   always_ff @(posedge clock) begin
      bkt_ff <= bkt_in;
      if (cb.load) begin
         cmd_ff    <= chte_pkg::cmd_type'(req_command);
         key_ff    <= req_key;
         vin_ff    <= req_value;
         pos_ff    <= req_position;
         quo_ff    <= req_key;
         rem_ff    <= '0;
         mcnt_ff   <= '0;
         before_ff <= '0;
      end
      if (cb.mod_step) begin
         quo_ff  <= quo_ff << 1;
         mcnt_ff <= mcnt_ff + KC'(1);
         rem_ff  <= rem_in;
      end
      if (cb.head_rd) begin
         cur_ff   <= head_rd_ff;
         prev_ff  <= NULL_L;
         steps_ff <= '0;
         if (cmd_ff == chte_pkg::CMD_AT) begin
            before_ff <= AB'(pos_ff) - before_ff;
         end
      end
      if (cb.walk_adv) begin
         if (cmd_ff == chte_pkg::CMD_AT) begin
            cur_ff    <= mlink[cur_a];
            before_ff <= before_ff - AB'(1);
         end else begin
            prev_ff  <= cur_ff;
            cur_ff   <= rlink_ff;
            steps_ff <= steps_ff + PB'(1);
         end
      end
      if (cb.cnt_adv) begin
         before_ff <= before_ff + AB'(cnt_len);
      end
   end

   // Pool counter; cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         link_pend_ff <= 1'b0;
      end else begin
         link_pend_ff <= 1'b0;
         if (cb.do_link) begin
            used_ff <= used_ff + PB'(1);
            if (prev_ff != NULL_L) begin
               link_pend_ff <= 1'b1;
            end
         end
      end
   end

   // Status toward the controller.
   always_comb begin
      st.clr_busy    = clr_busy;
      st.mod_done    = (mcnt_ff == KC'(KEY_BITS));
      st.ptr_null    = (cur_ff >= NULL_L);
      st.key_eq      = (rkey_ff == key_ff);
      st.key_gt      = (rkey_ff > key_ff);
      st.pool_full   = (used_ff >= NULL_L);
      st.walk_over   = (steps_ff >= NULL_L);
      st.pos_here    = (AB'(pos_ff) < before_ff + AB'(cnt_len));
      st.last_bucket = ((CB+1)'(bkt_ff) + (CB+1)'(1) >= (CB+1)'(eff));
      st.offset_zero = (before_ff == '0);
   end

endmodule

FILE: rtl/core/chained_hash_table_engine_unit.sv
// A key command first runs a bit-serial modulo of the key by the bucket count, then reads the
// chain head and compares the chain entries in turn; an insert then links the new entry.
// By position: buckets are counted up to the one that holds the position, then its chain is
// walked to the entry. Throughput: one transaction at a time.
// Reset is synchronous and active high; it sets the bucket count to 16, clears the pool
// count, and a clearing pass over MAX_BUCKETS buckets clears chain heads and lengths before requests.
module chained_hash_table_engine_unit #(
   parameter int MAX_BUCKETS  = 64,
   parameter int POOL_ENTRIES = 256,
   parameter int KEY_BITS     = 32,
   parameter int VALUE_BITS   = 32
) (
   input  logic       clock,
   input  logic       reset,
   chte_req_if.sink   req,
   chte_rsp_if.source rsp,
   input  logic       csr_we,
   input  logic [6:0] csr_wdata
);

   chte_pkg::cmd_bus_type  cb;
   chte_pkg::stat_bus_type st;
   chte_pkg::cmd_type      cmd;
   chte_pkg::status_type   res_status;
   logic                   idle;
   logic                   res_found;
   logic [VALUE_BITS-1:0]  val_rd;
   logic                   rsp_valid_ff;
   logic                   rsp_found_ff;
   logic [VALUE_BITS-1:0]  rsp_value_ff;
   logic [1:0]             rsp_status_ff;

   assign req.ready = idle;

   chte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req.valid && req.ready),
      .req_cmd    (chte_pkg::cmd_type'(req.command)),
      .cmd        (cmd),
      .rsp_busy   (rsp_valid_ff && !rsp.ready),
      .st         (st),
      .idle       (idle),
      .cb         (cb),
      .res_found  (res_found),
      .res_status (res_status)
   );

   chte_dp #(
      .MAX_BUCKETS  (MAX_BUCKETS),
      .POOL_ENTRIES (POOL_ENTRIES),
      .KEY_BITS     (KEY_BITS),
      .VALUE_BITS   (VALUE_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cb           (cb),
      .req_command  (req.command),
      .req_key      (req.key),
      .req_value    (req.value_in),
      .req_position (req.position),
      .csr_value    (csr_wdata),
      .csr_we       (csr_we),
      .st           (st),
      .cmd          (cmd),
      .val_rd       (val_rd)
   );

   // Output register for the response transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cb.set_resp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cb.set_resp) begin
         rsp_found_ff  <= res_found;
         rsp_value_ff  <= res_found ? val_rd : '0;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.found     = rsp_found_ff;
   assign rsp.value_out = rsp_value_ff;
   assign rsp.status    = rsp_status_ff;

endmodule

FILE: rtl/core/chte_checker.sv
module chte_sva (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_found,
   input logic [1:0] rsp_status
);

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_status))
      else $error("response dropped while stalled");

   // A found entry always reports ok.
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == chte_pkg::ST_OK)
      else $error("found with error status");

   // A request is followed by busy.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after request");

endmodule

bind chained_hash_table_engine_unit chte_sva u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_found  (rsp.found),
   .rsp_status (rsp.status)
);
